// ===== hdl/mss_pkg.sv =====
`default_nettype none
package mss_pkg;

  localparam int ElemW    = 16;
  localparam int CntW     = 8;
  localparam int PosW     = 7;
  localparam int SumW     = 31;
  localparam int SqW      = 45;
  localparam int ColW     = 23;
  localparam int ProdW    = 32;
  localparam int NW       = 15;
  localparam int NnW      = 29;
  localparam int StdW     = 24;
  localparam int MaxDim   = 128;
  localparam int CfgIdxW  = 2;
  localparam int QDepth   = 2;

  localparam logic [CfgIdxW-1:0] RegRowCount    = 2'd0;
  localparam logic [CfgIdxW-1:0] RegColumnCount = 2'd1;

  typedef struct packed {
    logic [ColW-1:0]         col_sum;
    logic [ProdW-1:0]        prod;
    logic signed [ElemW-1:0] max_val;
    logic [PosW-1:0]         max_row;
    logic [PosW-1:0]         max_col;
    logic [SumW-1:0]         sum;
    logic [SqW-1:0]          sq;
    logic [NW-1:0]           n;
  } mss_entry_t;

  function automatic logic [CntW-1:0] effective(input logic [CntW-1:0] r);
    logic [CntW-1:0] v;
    v = r;
    if (r == '0) v = CntW'(1);
    else if (r > CntW'(MaxDim)) v = CntW'(MaxDim);
    return v;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/mss_queue.sv =====
`default_nettype none
module mss_queue import mss_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       push,
  input  wire mss_entry_t push_data,
  output logic            full,
  input  wire logic       pop,
  output logic            pop_valid,
  output mss_entry_t      pop_data
);

  localparam int PtrW = (QDepth > 1) ? $clog2(QDepth) : 1;
  localparam int CntQW = $clog2(QDepth + 1);

  mss_entry_t slots [QDepth];
  logic [PtrW-1:0]  wr_ptr;
  logic [PtrW-1:0]  rd_ptr;
  logic [CntQW-1:0] count;

  assign full      = (count == CntQW'(QDepth));
  assign pop_valid = (count != '0);
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PtrW'(QDepth - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PtrW'(QDepth - 1)) ? '0 : rd_ptr + 1'b1;
      end
      count <= count + CntQW'(push) - CntQW'(pop);
    end
  end

endmodule
`default_nettype wire

// ===== hdl/mss_front.sv =====
`default_nettype none
module mss_front import mss_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CntW-1:0]     cfg_data,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire logic signed [ElemW-1:0] element_value,
  input  wire logic                q_full,
  output logic                     q_push,
  output mss_entry_t               q_data
);

  logic [CntW-1:0] row_count;
  logic [CntW-1:0] column_count;
  logic [PosW-1:0] row_position;
  logic [PosW-1:0] column_position;
  logic [SumW-1:0] running_sum;
  logic [SqW-1:0]  running_square_sum;
  logic signed [ElemW-1:0] best_value;
  logic [PosW-1:0] best_row;
  logic [PosW-1:0] best_column;
  logic [ColW-1:0] column_tail_sum;
  logic [ProdW-1:0] row_tail_product;

  logic [CntW-1:0] eff_rows;
  logic [CntW-1:0] eff_cols;
  logic            last_col;
  logic            last_row;
  logic            first;
  logic            take_best;
  logic            accept;
  logic signed [2*ElemW-1:0] sq_e;
  logic [ProdW-1:0] e32;
  logic [SumW-1:0]  running_sum_next;
  logic [SqW-1:0]   running_square_sum_next;
  logic [ColW-1:0]  column_tail_sum_next;
  logic [ProdW-1:0] row_tail_product_next;
  logic [2*CntW-1:0] n_full;

  assign cfg_ready = 1'b1;
  assign in_ready  = !q_full;
  assign accept    = in_valid && in_ready;

  assign eff_rows = effective(row_count);
  assign eff_cols = effective(column_count);
  assign last_col = ({1'b0, column_position} + CntW'(1)) >= eff_cols;
  assign last_row = ({1'b0, row_position} + CntW'(1)) >= eff_rows;
  assign first    = (row_position == '0) && (column_position == '0);
  assign take_best = first || (element_value > best_value);

  assign sq_e = element_value * element_value;
  assign e32  = {{(ProdW-ElemW){element_value[ElemW-1]}}, element_value};

  assign running_sum_next = running_sum
                          + {{(SumW-ElemW){element_value[ElemW-1]}}, element_value};
  assign running_square_sum_next = running_square_sum
                                 + {{(SqW-2*ElemW){1'b0}}, $unsigned(sq_e)};
  assign column_tail_sum_next = last_col
      ? column_tail_sum + {{(ColW-ElemW){element_value[ElemW-1]}}, element_value}
      : column_tail_sum;
  assign row_tail_product_next = last_row ? row_tail_product * e32 : row_tail_product;
  assign n_full = eff_rows * eff_cols;

  assign q_push = accept && last_col && last_row;

  always_comb begin
    q_data.col_sum = column_tail_sum_next;
    q_data.prod    = row_tail_product_next;
    q_data.max_val = take_best ? element_value : best_value;
    q_data.max_row = take_best ? row_position : best_row;
    q_data.max_col = take_best ? column_position : best_column;
    q_data.sum     = running_sum_next;
    q_data.sq      = running_square_sum_next;
    q_data.n       = n_full[NW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_count    <= CntW'(1);
      column_count <= CntW'(1);
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        RegRowCount:    row_count    <= cfg_data;
        RegColumnCount: column_count <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_position       <= '0;
      column_position    <= '0;
      running_sum        <= '0;
      running_square_sum <= '0;
      best_value         <= '0;
      best_row           <= '0;
      best_column        <= '0;
      column_tail_sum    <= '0;
      row_tail_product   <= ProdW'(1);
    end else if (accept) begin
      if (last_col && last_row) begin
        // matrix closed: start the next one afresh
        row_position       <= '0;
        column_position    <= '0;
        running_sum        <= '0;
        running_square_sum <= '0;
        best_value         <= '0;
        best_row           <= '0;
        best_column        <= '0;
        column_tail_sum    <= '0;
        row_tail_product   <= ProdW'(1);
      end else begin
        running_sum        <= running_sum_next;
        running_square_sum <= running_square_sum_next;
        column_tail_sum    <= column_tail_sum_next;
        row_tail_product   <= row_tail_product_next;
        if (take_best) begin
          best_value  <= element_value;
          best_row    <= row_position;
          best_column <= column_position;
        end
        if (!last_col) begin
          column_position <= column_position + 1'b1;
        end else begin
          column_position <= '0;
          row_position    <= row_position + 1'b1;
        end
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/mss_back.sv =====
`default_nettype none
module mss_back import mss_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       q_valid,
  input  wire mss_entry_t q_data,
  output logic            q_pop,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic signed [ColW-1:0]  last_column_sum,
  output logic signed [ProdW-1:0] last_row_product,
  output logic signed [ElemW-1:0] max_value,
  output logic [PosW-1:0]         max_row,
  output logic [PosW-1:0]         max_column,
  output logic [StdW-1:0]         std_deviation
);

  localparam int SaW    = SumW;
  localparam int S2W    = 2 * SaW;
  localparam int LoW    = 23;
  localparam int HiW    = SqW - LoW;
  localparam int AccW   = NW + SqW;
  localparam int DqW    = AccW + 16;
  localparam int RemDW  = NnW - 1;
  localparam int RootW  = S2W / 2;
  localparam int RemSW  = RootW + 2;
  localparam int StepW  = 7;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SQ    = 4'd1;
  localparam logic [3:0] S_NQLO  = 4'd2;
  localparam logic [3:0] S_NQHI  = 4'd3;
  localparam logic [3:0] S_ADD   = 4'd4;
  localparam logic [3:0] S_SUB   = 4'd5;
  localparam logic [3:0] S_DIV   = 4'd6;
  localparam logic [3:0] S_ROOT0 = 4'd7;
  localparam logic [3:0] S_SQRT  = 4'd8;
  localparam logic [3:0] S_OUT   = 4'd9;

  logic [3:0]       state;
  mss_entry_t       ent;
  logic [NnW-1:0]   nn;
  logic [SaW-1:0]   sa;
  logic [S2W-1:0]   s2;
  logic [AccW-1:0]  acc;
  logic [NW+HiW-1:0] prod_hi;
  logic [DqW-1:0]   dq;
  logic [RemDW-1:0] rem_d;
  logic [S2W-1:0]   xs;
  logic [RootW-1:0] root;
  logic [RemSW-1:0] rem_s;
  logic [StepW-1:0] step;

  logic [2*NW-1:0]   nn_full;
  logic [S2W-1:0]    sa_sq;
  logic [NW+LoW-1:0] nq_lo;
  logic [NW+HiW-1:0] nq_hi;
  logic [S2W-1:0]    diff;
  logic [NnW-1:0]    div_sh;
  logic              div_bit;
  logic [RemSW+1:0]  sq_sh;
  logic [RemSW+1:0]  sq_trial;
  logic              sq_bit;

  assign nn_full = q_data.n * q_data.n;
  assign sa_sq   = sa * sa;
  assign nq_lo   = ent.n * ent.sq[LoW-1:0];
  assign nq_hi   = ent.n * ent.sq[SqW-1:LoW];
  assign diff    = {{(S2W-AccW){1'b0}}, acc} - s2;
  assign div_sh  = {rem_d, dq[DqW-1]};
  assign div_bit = (div_sh >= nn);
  assign sq_sh    = {rem_s, xs[S2W-1:S2W-2]};
  assign sq_trial = {{(RemSW+2-RootW-2){1'b0}}, root, 2'b01};
  assign sq_bit   = (sq_sh >= sq_trial);

  assign q_pop     = (state == S_IDLE) && q_valid;
  assign out_valid = (state == S_OUT);

  assign last_column_sum  = ent.col_sum;
  assign last_row_product = ent.prod;
  assign max_value        = ent.max_val;
  assign max_row          = ent.max_row;
  assign max_column       = ent.max_col;
  assign std_deviation    = root[StdW-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      unique case (state)
        S_IDLE:  if (q_valid) state <= S_SQ;
        S_SQ:    state <= S_NQLO;
        S_NQLO:  state <= S_NQHI;
        S_NQHI:  state <= S_ADD;
        S_ADD:   state <= S_SUB;
        S_SUB:   state <= S_DIV;
        S_DIV:   if (step == '0) state <= S_ROOT0;
        S_ROOT0: state <= S_SQRT;
        S_SQRT:  if (step == '0) state <= S_OUT;
        S_OUT:   if (out_ready) state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        ent <= q_data;
        nn  <= nn_full[NnW-1:0];
        sa  <= q_data.sum[SumW-1] ? (~q_data.sum + 1'b1) : q_data.sum;
      end
      S_SQ:   s2      <= sa_sq;
      S_NQLO: acc     <= AccW'(nq_lo);
      S_NQHI: prod_hi <= nq_hi;
      S_ADD:  acc     <= acc + {prod_hi, {LoW{1'b0}}};
      S_SUB: begin
        // negative variance only after wrap: report zero
        if ({{(S2W-AccW){1'b0}}, acc} > s2) dq <= {diff[AccW-1:0], 16'b0};
        else dq <= '0;
        rem_d <= '0;
        step  <= StepW'(DqW - 1);
      end
      S_DIV: begin
        rem_d <= div_bit ? RemDW'(div_sh - nn) : div_sh[RemDW-1:0];
        dq    <= {dq[DqW-2:0], div_bit};
        step  <= step - 1'b1;
      end
      S_ROOT0: begin
        xs    <= dq[S2W-1:0];
        root  <= '0;
        rem_s <= '0;
        step  <= StepW'(RootW - 1);
      end
      S_SQRT: begin
        rem_s <= sq_bit ? RemSW'(sq_sh - sq_trial) : sq_sh[RemSW-1:0];
        root  <= {root[RootW-2:0], sq_bit};
        xs    <= {xs[S2W-3:0], 2'b00};
        step  <= step - 1'b1;
      end
      default: ;
    endcase
  end

`ifndef SYNTHESIS
  a_out_to_idle: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && out_ready) |=> (state == S_IDLE))
    else $error("back did not return to idle after result taken");
  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV) |-> ({1'b0, rem_d} < nn))
    else $error("divide remainder not below divisor");
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_DIV && step == '0) |=> (state == S_ROOT0))
    else $error("divide did not hand over to root");
`endif

endmodule
`default_nettype wire

// ===== hdl/matrix_stream_statistics.sv =====
`default_nettype none
// Streaming matrix statistics. Elements enter row-major, one word per cycle,
// and are accumulated at once; the last element of a matrix queues a snapshot
// (up to two matrices deep) for the back end. Per matrix it runs
// five set-up steps for the products, a 76-step restoring divide and a
// 31-step square root, then holds the result until out_ready. A stream that outruns
// the back end stalls input only once both queue slots are full.
module matrix_stream_statistics import mss_pkg::*; (
  input  wire logic                    clk,
  input  wire logic                    rst,
  input  wire logic                    cfg_valid,
  output logic                         cfg_ready,
  input  wire logic [CfgIdxW-1:0]      cfg_index,
  input  wire logic [CntW-1:0]         cfg_data,
  input  wire logic                    in_valid,
  output logic                         in_ready,
  input  wire logic signed [ElemW-1:0] element_value,
  output logic                         out_valid,
  input  wire logic                    out_ready,
  output logic signed [ColW-1:0]       last_column_sum,
  output logic signed [ProdW-1:0]      last_row_product,
  output logic signed [ElemW-1:0]      max_value,
  output logic [PosW-1:0]              max_row,
  output logic [PosW-1:0]              max_column,
  output logic [StdW-1:0]              std_deviation
);

  logic       q_full;
  logic       q_push;
  logic       q_pop;
  logic       q_valid;
  mss_entry_t push_data;
  mss_entry_t pop_data;

  mss_front u_front (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .element_value,
    .q_full, .q_push, .q_data(push_data)
  );

  mss_queue u_queue (
    .clk, .rst, .push(q_push), .push_data, .full(q_full),
    .pop(q_pop), .pop_valid(q_valid), .pop_data
  );

  mss_back u_back (
    .clk, .rst, .q_valid, .q_data(pop_data), .q_pop,
    .out_valid, .out_ready, .last_column_sum, .last_row_product,
    .max_value, .max_row, .max_column, .std_deviation
  );

endmodule
`default_nettype wire

// ===== tb/matrix_stream_statistics_tb.sv =====
`timescale 1ns / 1ps
module matrix_stream_statistics_tb;
  import mss_pkg::*;

  typedef struct {
    logic signed [ColW-1:0]  col_sum;
    logic signed [ProdW-1:0] prod;
    logic signed [ElemW-1:0] max_val;
    logic [PosW-1:0]         max_row;
    logic [PosW-1:0]         max_col;
    logic [StdW-1:0]         std_dev;
  } matrix_stats_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [CntW-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [ElemW-1:0] element_value = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [ColW-1:0] last_column_sum;
  logic signed [ProdW-1:0] last_row_product;
  logic signed [ElemW-1:0] max_value;
  logic [PosW-1:0] max_row;
  logic [PosW-1:0] max_column;
  logic [StdW-1:0] std_deviation;

  matrix_stream_statistics dut (
    .clk, .rst, .cfg_valid, .cfg_ready, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .element_value,
    .out_valid, .out_ready, .last_column_sum, .last_row_product,
    .max_value, .max_row, .max_column, .std_deviation
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // register mirror and accumulator copy
  logic [CntW-1:0] rows_reg = 8'd1;
  logic [CntW-1:0] cols_reg = 8'd1;
  int unsigned row_at, col_at;
  logic [SumW-1:0] sum_acc;
  logic [SqW-1:0] sq_acc;
  logic signed [ElemW-1:0] best_val;
  logic [PosW-1:0] best_r, best_c;
  logic [ColW-1:0] col_acc;
  logic [ProdW-1:0] prod_acc;

  logic signed [ElemW-1:0] elements_to_send[$];
  matrix_stats_t expected_stats[$];
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int errors = 0;
  int elements_taken = 0;
  int matrices_checked = 0;
  int cycles = 0;

  function automatic int unsigned clamp_count(input logic [CntW-1:0] r);
    if (r == '0) return 1;
    if (r > MaxDim) return MaxDim;
    return r;
  endfunction

  function automatic logic [63:0] int_sqrt(input logic [63:0] x);
    logic [63:0] root, bit_v;
    root = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > x) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (x >= root + bit_v) begin
        x = x - (root + bit_v);
        root = (root >> 1) + bit_v;
      end else begin
        root = root >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return root;
  endfunction

  task automatic clear_matrix();
    row_at = 0;
    col_at = 0;
    sum_acc = '0;
    sq_acc = '0;
    best_val = '0;
    best_r = '0;
    best_c = '0;
    col_acc = '0;
    prod_acc = 32'd1;
  endtask

  task automatic absorb_element(input logic signed [ElemW-1:0] e);
    int unsigned rows, cols;
    logic last_c, last_r, first;
    logic signed [63:0] e64, s;
    logic [63:0] sq64, n, n2, sa, s2, nq, d, q, rm, scaled, root64;
    matrix_stats_t res;
    rows = clamp_count(rows_reg);
    cols = clamp_count(cols_reg);
    e64 = e;
    sq64 = e64 * e64;
    last_c = (col_at + 1 >= cols);
    last_r = (row_at + 1 >= rows);
    first = (row_at == 0 && col_at == 0);
    sum_acc = sum_acc + e64[SumW-1:0];
    sq_acc = sq_acc + sq64[SqW-1:0];
    if (first || e > best_val) begin
      best_val = e;
      best_r = row_at[PosW-1:0];
      best_c = col_at[PosW-1:0];
    end
    if (last_c) col_acc = col_acc + e64[ColW-1:0];
    if (last_r) prod_acc = prod_acc * e64[31:0];
    if (!last_c) begin
      col_at++;
      return;
    end
    col_at = 0;
    if (!last_r) begin
      row_at++;
      return;
    end
    n = rows * cols;
    n2 = n * n;
    s = {{(64-SumW){sum_acc[SumW-1]}}, sum_acc};
    sa = (s < 0) ? -s : s;
    s2 = sa * sa;
    nq = n * {{(64-SqW){1'b0}}, sq_acc};
    scaled = 0;
    if (nq > s2) begin
      d = nq - s2;
      q = d / n2;
      rm = d % n2;
      scaled = (q << 16) + ((rm << 16) / n2);
    end
    root64 = int_sqrt(scaled);
    res.col_sum = col_acc;
    res.prod = prod_acc;
    res.max_val = best_val;
    res.max_row = best_r;
    res.max_col = best_c;
    res.std_dev = root64[StdW-1:0];
    expected_stats.push_back(res);
    clear_matrix();
  endtask

  task automatic report_mismatch(input string field, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch on matrix %0d: %s got %0h expected %0h",
             matrices_checked, field, got, want);
    errors++;
  endtask

  // driver: present the next queued word once the previous one has been taken
  logic in_taken = 1'b0;
  always @(posedge clk) begin
    in_taken = in_valid && in_ready;
    if (in_taken) begin
      absorb_element(element_value);
      elements_taken++;
    end
  end

  always @(negedge clk) begin
    if (!rst) begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
      if (!in_valid || in_taken) begin
        if (elements_to_send.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          element_value <= elements_to_send.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    matrix_stats_t want;
    if (out_valid && out_ready) begin
      if (expected_stats.size() == 0) begin
        $display("unexpected result word at cycle %0d", cycles);
        errors++;
      end else begin
        want = expected_stats.pop_front();
        if (last_column_sum !== want.col_sum)
          report_mismatch("last_column_sum", last_column_sum, want.col_sum);
        if (last_row_product !== want.prod)
          report_mismatch("last_row_product", last_row_product, want.prod);
        if (max_value !== want.max_val) report_mismatch("max_value", max_value, want.max_val);
        if (max_row !== want.max_row) report_mismatch("max_row", max_row, want.max_row);
        if (max_column !== want.max_col)
          report_mismatch("max_column", max_column, want.max_col);
        if (std_deviation !== want.std_dev)
          report_mismatch("std_deviation", std_deviation, want.std_dev);
        matrices_checked++;
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > 800000) begin
      $display("timeout after %0d cycles", cycles);
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [CntW-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == RegRowCount) rows_reg = val;
    else cols_reg = val;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // hold until every word is in, every result out, and the back end is quiet
  task automatic drain();
    while (elements_to_send.size() > 0 || in_valid || expected_stats.size() > 0)
      @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  task automatic set_dims(input logic [CntW-1:0] r, input logic [CntW-1:0] c);
    write_reg(RegRowCount, r);
    write_reg(RegColumnCount, c);
  endtask

  function automatic logic signed [ElemW-1:0] pick_element(input int style,
                                                           input logic signed [ElemW-1:0] fixed);
    case (style)
      0: return ElemW'($urandom);
      1: return ElemW'($urandom_range(16) - 8);
      2: begin
        case ($urandom_range(3))
          0: return 16'sh7fff;
          1: return 16'sh8000;
          2: return 16'sh0000;
          default: return -16'sd1;
        endcase
      end
      default: return fixed;
    endcase
  endfunction

  initial begin
    int mode, phase, rows, cols, n, mats, extra, style, big;
    logic signed [ElemW-1:0] fixed;
    clear_matrix();
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: extremes with a tie for the maximum
    set_dims(8'd2, 8'd3);
    elements_to_send = '{16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh0000, -16'sd1, 16'sd1};
    drain();
    set_dims(8'd1, 8'd1);
    elements_to_send = '{16'sh8000, 16'sh7fff};
    drain();
    // zero counts behave as one
    set_dims(8'd0, 8'd0);
    elements_to_send = '{16'sd5};
    drain();
    // constant matrix, zero deviation
    set_dims(8'd3, 8'd2);
    repeat (6) elements_to_send.push_back(-16'sd7);
    drain();
    // shrink the counts part-way through a matrix
    set_dims(8'd3, 8'd3);
    elements_to_send = '{16'sd3, -16'sd4, 16'sd9, 16'sd2};
    drain();
    write_reg(RegColumnCount, 8'd2);
    write_reg(RegRowCount, 8'd2);
    elements_to_send.push_back(16'sd11);
    drain();

    phase = 0;
    while (elements_taken < 480) begin
      mode = phase % 4;
      send_idle_pct = (mode == 1 || mode == 3) ? (mode == 1 ? 77 : 33) : 0;
      recv_stall_pct = (mode == 2 || mode == 3) ? (mode == 2 ? 77 : 33) : 0;
      big = ($urandom_range(9) == 0);
      if (big) begin
        rows = ($urandom_range(1)) ? 128 + $urandom_range(127) * $urandom_range(1) : 1;
        cols = (rows == 1) ? 128 + $urandom_range(127) * $urandom_range(1) : $urandom_range(1);
      end else begin
        rows = $urandom_range(6);
        cols = $urandom_range(6);
      end
      set_dims(rows[CntW-1:0], cols[CntW-1:0]);
      n = clamp_count(rows[CntW-1:0]) * clamp_count(cols[CntW-1:0]);
      mats = big ? 1 : 1 + $urandom_range(3);
      extra = (n > 1 && $urandom_range(3) == 0) ? $urandom_range(n - 1, 1) : 0;
      style = $urandom_range(3);
      fixed = ElemW'($urandom);
      repeat (mats * n + extra) elements_to_send.push_back(pick_element(style, fixed));
      drain();
      phase++;
    end

    $display("%0d elements taken, %0d matrices checked over %0d random settings",
             elements_taken, matrices_checked, phase);
    $display("covered zero and oversized counts, count changes mid-matrix, stalls on both sides");
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
